// File: hw/rtl/lqg_pkg.sv
package lqg_pkg;

    // Geometry of one quantization block
    localparam int BLOCK_ELEMENTS = 32;
    localparam int LANES          = BLOCK_ELEMENTS / 2;
    localparam int LANE_W         = $clog2(LANES);

    // Row accumulator width and saturation bounds
    localparam int ACC_W = 48;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Result word width and saturation bounds
    localparam int OUT_W = 32;
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // Weight format codes
    localparam int FMT_W = 3;
    localparam logic [FMT_W-1:0] FMT_Q4_0   = 3'd0;
    localparam logic [FMT_W-1:0] FMT_Q4_1   = 3'd1;
    localparam logic [FMT_W-1:0] FMT_Q5_0   = 3'd2;
    localparam logic [FMT_W-1:0] FMT_Q5_1   = 3'd3;
    localparam logic [FMT_W-1:0] FMT_IQ4_NL = 3'd4;

    // Offsets removed from symmetric codes
    localparam logic signed [7:0] Q4_OFFSET = 8'sd8;
    localparam logic signed [7:0] Q5_OFFSET = 8'sd16;

    // fp16 exponent field at infinity/NaN
    localparam logic [4:0] EXP_SPECIAL = 5'd31;
    // Fixed-point fraction of the decoded half scale
    localparam int HALF_FRAC = 24;
    // Largest left shift of a mantissa product (exponent 30)
    localparam int HALF_SHIFT_MAX = 29;

    // Nonlinear 4-bit codebook
    localparam logic signed [7:0] NL_TABLE [0:15] = '{
        -8'sd127, -8'sd104, -8'sd83, -8'sd65, -8'sd49, -8'sd35, -8'sd22, -8'sd10,
        8'sd1,    8'sd13,   8'sd25,  8'sd38,  8'sd53,  8'sd69,  8'sd89,  8'sd113
    };

    typedef enum logic [1:0] {
        ST_RUN,
        ST_MUL,
        ST_SHIFT,
        ST_SUM
    } t_state;

    // Turn one 4-bit code (plus fifth bit) into a signed weight
    function automatic logic signed [7:0] decode_code(
        input logic [FMT_W-1:0] fmt,
        input logic [3:0]       nib,
        input logic             fifth
    );
        logic signed [7:0] r;
        case (fmt)
            FMT_Q4_1:   r = $signed({4'b0, nib});
            FMT_Q5_0:   r = $signed({3'b0, fifth, nib}) - Q5_OFFSET;
            FMT_Q5_1:   r = $signed({3'b0, fifth, nib});
            FMT_IQ4_NL: r = NL_TABLE[nib];
            default:    r = $signed({4'b0, nib}) - Q4_OFFSET;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/lqg_in_if.sv
interface lqg_in_if #(
    parameter int ACT_W = 16
);
    logic                    valid;
    logic                    ready;
    logic [7:0]              code_byte;
    logic signed [ACT_W-1:0] act_low;
    logic signed [ACT_W-1:0] act_high;
    logic [15:0]             scale_half;
    logic [15:0]             min_bits;
    logic [31:0]             fifth_bits;
    logic                    row_end;

    modport source (
        output valid, code_byte, act_low, act_high, scale_half, min_bits,
               fifth_bits, row_end,
        input  ready
    );
    modport sink (
        input  valid, code_byte, act_low, act_high, scale_half, min_bits,
               fifth_bits, row_end,
        output ready
    );
endinterface

// File: hw/rtl/lqg_out_if.sv
interface lqg_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] row_sum;

    modport source (
        output valid, row_sum,
        input  ready
    );
    modport sink (
        input  valid, row_sum,
        output ready
    );
endinterface

// File: hw/rtl/lqg_lane.sv
module lqg_lane #(
    parameter int ACT_W = 16
) (
    input  logic [lqg_pkg::FMT_W-1:0] i_fmt,
    input  logic [3:0]                i_nib,
    input  logic                      i_fifth,
    input  logic signed [ACT_W-1:0]   i_act,
    output logic signed [ACT_W+7:0]   o_prod
);
    logic signed [7:0] w_weight;

    assign w_weight = lqg_pkg::decode_code(i_fmt, i_nib, i_fifth);
    assign o_prod   = w_weight * i_act;

endmodule

// File: hw/rtl/lqg_half_mul.sv
module lqg_half_mul #(
    parameter int X_W = 29
) (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  logic [15:0]           i_bits,
    input  logic signed [X_W-1:0] i_x,
    output logic signed [X_W+16:0] o_term
);
    localparam int PW = X_W + 12;
    localparam int WW = PW + lqg_pkg::HALF_SHIFT_MAX;

    logic [4:0]           w_exp;
    logic [10:0]          w_mag;
    logic [4:0]           w_shift;
    logic signed [11:0]   w_mant;
    logic signed [PW-1:0] w_prod;
    logic signed [WW-1:0] w_wide;

    logic signed [PW-1:0]  r_prod;
    logic [4:0]            r_shift;
    logic signed [X_W+16:0] r_term;

    // Map fp16 to signed mantissa and left shift; value = mant * 2^(shift - 24)
    always_comb begin
        w_exp = i_bits[14:10];
        if (w_exp == 5'd0) begin
            w_mag   = {1'b0, i_bits[9:0]};
            w_shift = 5'd0;
        end else if (w_exp == lqg_pkg::EXP_SPECIAL) begin
            w_mag   = 11'h7FF;
            w_shift = 5'(lqg_pkg::HALF_SHIFT_MAX);
        end else begin
            w_mag   = {1'b1, i_bits[9:0]};
            w_shift = w_exp - 5'd1;
        end
        w_mant = i_bits[15] ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
        w_prod = w_mant * i_x;
    end

    // Shift into place, drop 24 fraction bits with floor rounding
    assign w_wide = WW'(r_prod) <<< r_shift;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod  <= w_prod;
            r_shift <= w_shift;
        end
        r_term <= w_wide[WW-1:lqg_pkg::HALF_FRAC];
    end

    assign o_term = r_term;

endmodule

// File: hw/rtl/legacy_quant_block_gemv.sv
// Quantized weight row times activation vector, GGUF legacy block formats.
//
// i_item (sink): one transfer per weight byte. Sixteen transfers make one
//   32-element block; transfer j carries elements j (low nibble) and j+16
//   (high nibble) plus their activations. Scale, min and fifth bits are
//   sampled on the first transfer of each block. row_end marks the last
//   transfer of a row and closes a partial block at once.
// o_result (source): one row_sum transfer per row, saturated to 32 bits.
// i_cfg_we / i_cfg_data: weight format; write only while the block is idle.
//
// Throughput: one item per cycle inside a block. Closing a block runs the
// scale and min multipliers, the shift stage and the accumulator add, and
// i_item.ready stays low through ST_MUL, ST_SHIFT and ST_SUM.
// A row result is registered in the output register after ST_SUM.
// Reset clears all accumulators and selects Q4_0.
// When the receiver stalls, the result holds in the output register and
// items keep flowing; only the next row end waits for the register to free.
module legacy_quant_block_gemv #(
    parameter int ACT_WIDTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lqg_pkg::FMT_W-1:0] i_cfg_data,
    lqg_in_if.sink                    i_item,
    lqg_out_if.source                 o_result
);
    localparam int DOT_W  = ACT_WIDTH + 13;
    localparam int ASUM_W = ACT_WIDTH + 6;
    localparam int TD_W   = DOT_W + 17;
    localparam int TM_W   = ASUM_W + 17;
    localparam int ACC_W  = lqg_pkg::ACC_W;
    localparam int SUM_W  = ((ACC_W > TD_W) ? ACC_W : TD_W) + 2;
    localparam int LANE_W = lqg_pkg::LANE_W;
    localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(lqg_pkg::LANES - 1);

    lqg_pkg::t_state r_state, n_state;

    logic [lqg_pkg::FMT_W-1:0] r_fmt;
    logic [LANE_W-1:0]         r_lane, n_lane;
    logic signed [DOT_W-1:0]   r_dot, n_dot;
    logic signed [ASUM_W-1:0]  r_asum, n_asum;
    logic [15:0]               r_scale, n_scale;
    logic [15:0]               r_min, n_min;
    logic [31:0]               r_fifth, n_fifth;
    logic                      r_end, n_end;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic                      r_out_valid, n_out_valid;
    logic signed [31:0]        r_row_sum, n_row_sum;

    logic                      w_accept;
    logic                      w_first;
    logic                      w_close;
    logic                      w_affine;
    logic [31:0]               w_fifth;
    logic [lqg_pkg::LANES-1:0] w_fifth_lo;
    logic [lqg_pkg::LANES-1:0] w_fifth_hi;
    logic signed [ACT_WIDTH+7:0] w_prod_lo;
    logic signed [ACT_WIDTH+7:0] w_prod_hi;
    logic signed [TD_W-1:0]    w_term_dot;
    logic signed [TM_W-1:0]    w_term_min;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [ACC_W-1:0]   w_acc_sat;
    logic signed [31:0]        w_row_sat;
    logic                      w_out_free;

    assign w_accept = i_item.valid && i_item.ready;
    assign w_first  = (r_lane == '0);
    assign w_close  = i_item.row_end || (r_lane == LAST_LANE);
    assign w_affine = (r_fmt == lqg_pkg::FMT_Q4_1) || (r_fmt == lqg_pkg::FMT_Q5_1);

    // Fifth bits come straight from the item on the first lane
    assign w_fifth    = w_first ? i_item.fifth_bits : r_fifth;
    assign w_fifth_lo = w_fifth[lqg_pkg::LANES-1:0];
    assign w_fifth_hi = w_fifth[lqg_pkg::BLOCK_ELEMENTS-1:lqg_pkg::LANES];

    // Two multiply lanes: low and high nibble of the code byte
    lqg_lane #(.ACT_W(ACT_WIDTH)) u_lane_lo (
        .i_fmt   (r_fmt),
        .i_nib   (i_item.code_byte[3:0]),
        .i_fifth (w_fifth_lo[r_lane]),
        .i_act   (i_item.act_low),
        .o_prod  (w_prod_lo)
    );

    lqg_lane #(.ACT_W(ACT_WIDTH)) u_lane_hi (
        .i_fmt   (r_fmt),
        .i_nib   (i_item.code_byte[7:4]),
        .i_fifth (w_fifth_hi[r_lane]),
        .i_act   (i_item.act_high),
        .o_prod  (w_prod_hi)
    );

    // Block close: scale * dot and min * activation sum, each through a product register and a term register
    lqg_half_mul #(.X_W(DOT_W)) u_scale_mul (
        .i_clk  (i_clk),
        .i_load (r_state == lqg_pkg::ST_MUL),
        .i_bits (r_scale),
        .i_x    (r_dot),
        .o_term (w_term_dot)
    );

    lqg_half_mul #(.X_W(ASUM_W)) u_min_mul (
        .i_clk  (i_clk),
        .i_load (r_state == lqg_pkg::ST_MUL),
        .i_bits (r_min),
        .i_x    (r_asum),
        .o_term (w_term_min)
    );

    // Merge the dot term (and the min term for Q4_1/Q5_1) into the row accumulator, saturate to 48 bits
    always_comb begin
        w_sum = SUM_W'(r_acc) + SUM_W'(w_term_dot)
              + (w_affine ? SUM_W'(w_term_min) : '0);
        if (w_sum > SUM_W'(lqg_pkg::ACC_MAX)) begin
            w_acc_sat = lqg_pkg::ACC_MAX;
        end else if (w_sum < SUM_W'(lqg_pkg::ACC_MIN)) begin
            w_acc_sat = lqg_pkg::ACC_MIN;
        end else begin
            w_acc_sat = w_sum[ACC_W-1:0];
        end
        if (w_acc_sat > ACC_W'(lqg_pkg::OUT_MAX)) begin
            w_row_sat = lqg_pkg::OUT_MAX;
        end else if (w_acc_sat < ACC_W'(lqg_pkg::OUT_MIN)) begin
            w_row_sat = lqg_pkg::OUT_MIN;
        end else begin
            w_row_sat = w_acc_sat[31:0];
        end
    end

    assign w_out_free = !r_out_valid || o_result.ready;

    always_comb begin
        n_state     = r_state;
        n_lane      = r_lane;
        n_dot       = r_dot;
        n_asum      = r_asum;
        n_scale     = r_scale;
        n_min       = r_min;
        n_fifth     = r_fifth;
        n_end       = r_end;
        n_acc       = r_acc;
        n_row_sum   = r_row_sum;
        n_out_valid = r_out_valid && !o_result.ready;
        i_item.ready = 1'b0;

        case (r_state)
            lqg_pkg::ST_RUN: begin
                i_item.ready = 1'b1;
                if (w_accept) begin
                    if (w_first) begin
                        n_scale = i_item.scale_half;
                        n_min   = i_item.min_bits;
                        n_fifth = i_item.fifth_bits;
                    end
                    n_dot  = r_dot + DOT_W'(w_prod_lo) + DOT_W'(w_prod_hi);
                    n_asum = r_asum + ASUM_W'(i_item.act_low) + ASUM_W'(i_item.act_high);
                    n_end  = i_item.row_end;
                    if (w_close) begin
                        n_lane  = '0;
                        n_state = lqg_pkg::ST_MUL;
                    end else begin
                        n_lane = r_lane + LANE_W'(1);
                    end
                end
            end
            lqg_pkg::ST_MUL: begin
                // Products captured this edge; clear the block sums
                n_dot   = '0;
                n_asum  = '0;
                n_state = lqg_pkg::ST_SHIFT;
            end
            lqg_pkg::ST_SHIFT: begin
                n_state = lqg_pkg::ST_SUM;
            end
            lqg_pkg::ST_SUM: begin
                if (!r_end) begin
                    n_acc   = w_acc_sat;
                    n_state = lqg_pkg::ST_RUN;
                end else if (w_out_free) begin
                    n_acc       = '0;
                    n_row_sum   = w_row_sat;
                    n_out_valid = 1'b1;
                    n_state     = lqg_pkg::ST_RUN;
                end
            end
            default: begin
                n_state = lqg_pkg::ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lqg_pkg::ST_RUN;
            r_fmt       <= lqg_pkg::FMT_Q4_0;
            r_lane      <= '0;
            r_dot       <= '0;
            r_asum      <= '0;
            r_scale     <= '0;
            r_min       <= '0;
            r_fifth     <= '0;
            r_end       <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lane      <= n_lane;
            r_dot       <= n_dot;
            r_asum      <= n_asum;
            r_scale     <= n_scale;
            r_min       <= n_min;
            r_fifth     <= n_fifth;
            r_end       <= n_end;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_fmt <= i_cfg_data;
            end
        end
    end

    // Payload register; valid flag guards it
    always_ff @(posedge i_clk) begin
        r_row_sum <= n_row_sum;
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.row_sum = r_row_sum;

    // A block close always starts the multiply sequence on the next cycle
    a_close_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_close) |=> (r_state == lqg_pkg::ST_MUL && r_lane == '0))
        else $error("block close did not start multiply sequence");

    // Block sums are cleared once the products are captured
    a_block_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lqg_pkg::ST_SHIFT) |-> (r_dot == '0 && r_asum == '0))
        else $error("block sums not cleared after close");

    // A finished row leaves a valid result and an empty accumulator
    a_row_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lqg_pkg::ST_SUM && r_end && w_out_free)
        |=> (r_out_valid && r_acc == '0 && r_state == lqg_pkg::ST_RUN))
        else $error("row result not delivered");

    // No item is taken while a block close is in flight
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != lqg_pkg::ST_RUN) |-> !i_item.ready)
        else $error("item accepted during block close");

endmodule
